// ===== rtl/bdf2ri_pkg.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - shared package
// Widths, datapath command codes, the command and status structs, and the
// saturating fixed-point helpers used by the datapath and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package bdf2ri_pkg;

  // Value format: signed Q16.32 in 48 bits, step length unsigned Q0.32.
  localparam int VW     = 48;
  localparam int FB     = 32;
  localparam int DT_W   = 32;
  localparam int SUM_W  = VW + 4;            // room for 3a - 4b + c
  localparam int PROD_W = 2 * VW;            // full multiplier product
  localparam int MCH    = 16;                // multiplier chunk per cycle
  localparam int MSTEPS = VW / MCH;
  localparam int MCNT_W = 2;
  localparam int NUM_W  = VW - 1 + DT_W + 2; // dividend of the correction
  localparam int DEN_W  = VW + 5;            // 9*I + 6*D*dt stays below 2^52
  localparam int Q_W    = NUM_W + 1;         // quotient after rounding
  localparam int DCNT_W = 7;

  localparam int IN_W   = DT_W + VW;
  localparam int OUT_W  = 3 * VW;
  localparam int CIDX_W = 2;

  localparam logic [VW-1:0] MAX_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MIN_NEG = {1'b1, {(VW-1){1'b0}}};

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] REG_TORQUE_MODE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_PRESC_RATE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INERTIA     = 2'd2;
  localparam logic [CIDX_W-1:0] REG_DAMPING     = 2'd3;

  // Datapath operations.
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_SHIFT     = 5'd2;
  localparam logic [4:0] OP_MUL       = 5'd3;
  localparam logic [4:0] OP_DIV       = 5'd4;
  localparam logic [4:0] OP_AN_MRES   = 5'd5;
  localparam logic [4:0] OP_AN_CORR   = 5'd6;
  localparam logic [4:0] OP_COMB_A    = 5'd7;
  localparam logic [4:0] OP_COMB_W    = 5'd8;
  localparam logic [4:0] OP_RN_DIV    = 5'd9;
  localparam logic [4:0] OP_TI        = 5'd10;
  localparam logic [4:0] OP_TD        = 5'd11;
  localparam logic [4:0] OP_TT        = 5'd12;
  localparam logic [4:0] OP_NUM       = 5'd13;
  localparam logic [4:0] OP_DEN       = 5'd14;
  localparam logic [4:0] OP_CORR_DIV  = 5'd15;
  localparam logic [4:0] OP_CORR_ZERO = 5'd16;
  localparam logic [4:0] OP_CORR_MRES = 5'd17;
  localparam logic [4:0] OP_OUT       = 5'd18;

  // Multiplier operand selects.
  localparam logic [2:0] MS_PRED = 3'd0;
  localparam logic [2:0] MS_TI   = 3'd1;
  localparam logic [2:0] MS_DW   = 3'd2;
  localparam logic [2:0] MS_TD   = 3'd3;
  localparam logic [2:0] MS_TT   = 3'd4;
  localparam logic [2:0] MS_DEN  = 3'd5;
  localparam logic [2:0] MS_M    = 3'd6;
  localparam logic [2:0] MS_PRES = 3'd7;

  // Divider operand selects.
  localparam logic DS_RATE = 1'b0;
  localparam logic DS_CORR = 1'b1;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] msel;
    logic       dsel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
    logic torque_mode;
  } status_t;

  function automatic logic [SUM_W-1:0] sx(input logic [VW-1:0] v);
    return {{(SUM_W-VW){v[VW-1]}}, v};
  endfunction

  // Clamp a wide two's-complement value to the signed value range.
  function automatic logic [VW-1:0] sat_val(input logic [SUM_W-1:0] x);
    if (x[SUM_W-1:VW-1] != {(SUM_W-VW+1){x[SUM_W-1]}}) begin
      return x[SUM_W-1] ? MIN_NEG : MAX_POS;
    end
    return x[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return sat_val(sx(a) + sx(b));
  endfunction

  // sat(3*a0 - 4*a1 + a2)
  function automatic logic [VW-1:0] comb3(input logic [VW-1:0] a0, input logic [VW-1:0] a1,
                                          input logic [VW-1:0] a2);
    logic [SUM_W-1:0] s;
    s = (sx(a0) << 1) + sx(a0) - (sx(a1) << 2) + sx(a2);
    return sat_val(s);
  endfunction

  function automatic logic [VW-1:0] vmag(input logic [VW-1:0] v);
    return v[VW-1] ? (VW'(0) - v) : v;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed value range.
  function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [Q_W-1:0] m);
    if (!neg) begin
      return (m > Q_W'(MAX_POS)) ? MAX_POS : m[VW-1:0];
    end
    return (m > Q_W'(MIN_NEG)) ? MIN_NEG : (VW'(0) - m[VW-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bdf2ri_mul.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - shared multiplier
// Unsigned 48x48 product built from three 48x16 partial products, one per
// cycle, then a final step that rounds half away from zero and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf2ri_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bdf2ri_pkg::VW-1:0]    a,
  input  wire logic [bdf2ri_pkg::VW-1:0]    b,
  input  wire logic                         neg,
  input  wire logic                         hi,     // round away FB+1 bits
  output logic                              done,
  output logic [bdf2ri_pkg::PROD_W-1:0]     prod,
  output logic [bdf2ri_pkg::VW-1:0]         res
);
  import bdf2ri_pkg::*;

  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  logic              done_r;
  logic [VW-1:0]     a_r, b_r;
  logic              neg_r, hi_r;
  logic [PROD_W-1:0] acc_r;
  logic [VW-1:0]     res_r;
  logic [VW+MCH-1:0] pp;
  logic [PROD_W:0]   rnd_sum;
  logic [PROD_W:0]   rnd_q;

  assign pp      = a_r * b_r[VW-1 -: MCH];
  assign rnd_sum = {1'b0, acc_r} + (hi_r ? ((PROD_W+1)'(1) << FB) : ((PROD_W+1)'(1) << (FB-1)));
  assign rnd_q   = hi_r ? (rnd_sum >> (FB + 1)) : (rnd_sum >> FB);

  always_comb begin
    cnt_nxt = cnt_r;
    fin_nxt = 1'b0;
    if (start) begin
      cnt_nxt = MCNT_W'(MSTEPS);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      fin_nxt = (cnt_r == MCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      neg_r <= neg;
      hi_r  <= hi;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= (acc_r << MCH) + PROD_W'(pp);
      b_r   <= b_r << MCH;
    end
    if (fin_r) begin
      res_r <= sat_mag(neg_r, Q_W'(rnd_q));
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ===== rtl/bdf2ri_div.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - serial divider
// Restoring division, one quotient bit per cycle, then a final step that
// rounds half up, applies the sign and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf2ri_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bdf2ri_pkg::NUM_W-1:0] num,
  input  wire logic [bdf2ri_pkg::DEN_W-1:0] den,
  input  wire logic                         neg,
  output logic                              done,
  output logic [bdf2ri_pkg::VW-1:0]         res
);
  import bdf2ri_pkg::*;

  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  logic              done_r;
  logic [NUM_W-1:0]  n_r, q_r;
  logic [DEN_W-1:0]  d_r, r_r;
  logic              neg_r;
  logic [VW-1:0]     res_r;
  logic [DEN_W:0]    r_sh, r_sub;
  logic              ge;
  logic              rnd;

  assign r_sh  = {r_r, n_r[NUM_W-1]};
  assign ge    = (r_sh >= {1'b0, d_r});
  assign r_sub = r_sh - {1'b0, d_r};
  assign rnd   = ({r_r, 1'b0} >= {1'b0, d_r});

  always_comb begin
    cnt_nxt = cnt_r;
    fin_nxt = 1'b0;
    if (start) begin
      cnt_nxt = DCNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      fin_nxt = (cnt_r == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      neg_r <= neg;
      r_r   <= '0;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      n_r <= n_r << 1;
      q_r <= {q_r[NUM_W-2:0], ge};
      r_r <= ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
    end
    if (fin_r) begin
      res_r <= sat_mag(neg_r, {1'b0, q_r} + Q_W'(rnd));
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ===== rtl/bdf2ri_dp.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - datapath
// Configuration, angle and rate histories, solver temporaries, output
// registers, and the shared multiplier and divider with their operand muxes.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf2ri_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bdf2ri_pkg::cmd_t              cmd,
  output bdf2ri_pkg::status_t                status,
  input  wire logic                          cfg_we,
  input  wire logic [bdf2ri_pkg::CIDX_W-1:0] cfg_idx,
  input  wire logic [bdf2ri_pkg::VW-1:0]     cfg_wdata,
  input  wire logic [bdf2ri_pkg::DT_W-1:0]   step_dt,
  input  wire logic [bdf2ri_pkg::VW-1:0]     applied_torque,
  output logic [bdf2ri_pkg::VW-1:0]          angle,
  output logic [bdf2ri_pkg::VW-1:0]          rate,
  output logic [bdf2ri_pkg::VW-1:0]          correction,
  output logic                               singular
);
  import bdf2ri_pkg::*;

  // Configuration and architectural state.
  logic          mode_r;
  logic [VW-1:0] pr_r, inert_r, damp_r;
  logic [VW-1:0] an_r, ap_r, ap2_r, rn_r, rp_r, rp2_r;

  // Per-step temporaries.
  logic [DT_W-1:0]  t_r;
  logic [VW-1:0]    tq_r, s_r, ti_r, td_r, tt_r, num_r, corr_r;
  logic [DEN_W-1:0] den_r;
  logic             sing_r;
  logic [VW-1:0]    oa_r, orate_r, oc_r;
  logic             os_r;

  logic              mul_start, mul_neg, mul_hi, mul_done;
  logic [VW-1:0]     mul_a, mul_b, mres;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start, div_neg, div_done;
  logic [NUM_W-1:0]  div_n;
  logic [DEN_W-1:0]  div_d;
  logic [VW-1:0]     dres;
  logic [PROD_W-1:0] damp_rnd;

  assign mul_start = (cmd.op == OP_MUL);
  assign div_start = (cmd.op == OP_DIV);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_hi  = 1'b0;
    case (cmd.msel)
      MS_PRED: begin
        mul_a = vmag(rp_r); mul_b = VW'(t_r); mul_neg = rp_r[VW-1];
      end
      MS_TI: begin
        mul_a = inert_r; mul_b = vmag(s_r); mul_neg = s_r[VW-1]; mul_hi = 1'b1;
      end
      MS_DW: begin
        mul_a = damp_r; mul_b = vmag(rn_r); mul_neg = rn_r[VW-1];
      end
      MS_TD: begin
        mul_a = vmag(mres); mul_b = VW'(t_r); mul_neg = mres[VW-1];
      end
      MS_TT: begin
        mul_a = vmag(tq_r); mul_b = VW'(t_r); mul_neg = tq_r[VW-1];
      end
      MS_DEN: begin
        mul_a = damp_r; mul_b = VW'({t_r, 2'b00}) + VW'({t_r, 1'b0});
      end
      MS_M: begin
        mul_a = vmag(num_r); mul_b = VW'(t_r);
      end
      MS_PRES: begin
        mul_a = vmag(pr_r); mul_b = VW'(t_r); mul_neg = pr_r[VW-1];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.dsel == DS_CORR) begin
      div_n   = {mul_prod[NUM_W-3:0], 2'b00};
      div_d   = den_r;
      div_neg = num_r[VW-1];
    end else begin
      div_n   = NUM_W'({vmag(s_r), {(FB-1){1'b0}}});
      div_d   = DEN_W'(t_r);
      div_neg = s_r[VW-1];
    end
  end

  // round(D*6*dt / 2^32) for the denominator; the full product is kept.
  assign damp_rnd = mul_prod + (PROD_W'(1) << (FB-1));

  bdf2ri_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .neg   (mul_neg),
    .hi    (mul_hi),
    .done  (mul_done),
    .prod  (mul_prod),
    .res   (mres)
  );

  bdf2ri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .neg   (div_neg),
    .done  (div_done),
    .res   (dres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      pr_r    <= '0;
      inert_r <= '0;
      damp_r  <= '0;
      an_r    <= '0;
      ap_r    <= '0;
      ap2_r   <= '0;
      rn_r    <= '0;
      rp_r    <= '0;
      rp2_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TORQUE_MODE: mode_r  <= cfg_wdata[0];
          REG_PRESC_RATE:  pr_r    <= cfg_wdata;
          REG_INERTIA:     inert_r <= cfg_wdata;
          REG_DAMPING:     damp_r  <= cfg_wdata;
          default:         mode_r  <= mode_r;
        endcase
      end
      case (cmd.op)
        OP_SHIFT: begin
          ap2_r <= ap_r;
          ap_r  <= an_r;
          rp2_r <= rp_r;
          rp_r  <= rn_r;
        end
        OP_AN_MRES: an_r <= sat_add(an_r, mres);
        OP_AN_CORR: an_r <= sat_add(an_r, corr_r);
        OP_RN_DIV:  rn_r <= dres;
        default:    an_r <= an_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        t_r    <= (step_dt == '0) ? DT_W'(1) : step_dt;
        tq_r   <= applied_torque;
        sing_r <= 1'b0;
      end
      OP_COMB_A:    s_r   <= comb3(an_r, ap_r, ap2_r);
      OP_COMB_W:    s_r   <= comb3(rn_r, rp_r, rp2_r);
      OP_TI:        ti_r  <= mres;
      OP_TD:        td_r  <= mres;
      OP_TT:        tt_r  <= mres;
      OP_NUM:       num_r <= sat_val(sx(tt_r) - sx(ti_r) - sx(td_r));
      OP_DEN: begin
        den_r <= DEN_W'({inert_r, 3'b000}) + DEN_W'(inert_r)
               + DEN_W'(damp_rnd[PROD_W-1:FB]);
      end
      OP_CORR_DIV:  corr_r <= dres;
      OP_CORR_MRES: corr_r <= mres;
      OP_CORR_ZERO: begin
        corr_r <= '0;
        sing_r <= 1'b1;
      end
      OP_OUT: begin
        oa_r    <= an_r;
        orate_r <= mode_r ? rn_r : pr_r;
        oc_r    <= corr_r;
        os_r    <= sing_r;
      end
      default: begin
        t_r <= t_r;
      end
    endcase
  end

  assign status.mul_done    = mul_done;
  assign status.div_done    = div_done;
  assign status.den_zero    = (den_r == '0);
  assign status.torque_mode = mode_r;

  assign angle      = oa_r;
  assign rate       = orate_r;
  assign correction = oc_r;
  assign singular   = os_r;

endmodule

`default_nettype wire

// ===== rtl/bdf2ri_ctrl.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - controller
// Sequences one time step through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf2ri_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire bdf2ri_pkg::status_t status,
  output bdf2ri_pkg::cmd_t         cmd
);
  import bdf2ri_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SHIFT = 5'd1;
  localparam logic [4:0] S_PRED  = 5'd2;
  localparam logic [4:0] S_WMUL  = 5'd3;
  localparam logic [4:0] S_WDIV  = 5'd4;
  localparam logic [4:0] S_ANP   = 5'd5;
  localparam logic [4:0] S_CA1   = 5'd6;
  localparam logic [4:0] S_DR1   = 5'd7;
  localparam logic [4:0] S_RN1   = 5'd8;
  localparam logic [4:0] S_CW    = 5'd9;
  localparam logic [4:0] S_MTI   = 5'd10;
  localparam logic [4:0] S_TI    = 5'd11;
  localparam logic [4:0] S_MDW   = 5'd12;
  localparam logic [4:0] S_MTD   = 5'd13;
  localparam logic [4:0] S_TD    = 5'd14;
  localparam logic [4:0] S_MTT   = 5'd15;
  localparam logic [4:0] S_TT    = 5'd16;
  localparam logic [4:0] S_NUM   = 5'd17;
  localparam logic [4:0] S_MDEN  = 5'd18;
  localparam logic [4:0] S_DEN   = 5'd19;
  localparam logic [4:0] S_CHK   = 5'd20;
  localparam logic [4:0] S_DC    = 5'd21;
  localparam logic [4:0] S_CORR  = 5'd22;
  localparam logic [4:0] S_ANC   = 5'd23;
  localparam logic [4:0] S_CA2   = 5'd24;
  localparam logic [4:0] S_DR2   = 5'd25;
  localparam logic [4:0] S_RN2   = 5'd26;
  localparam logic [4:0] S_PMUL  = 5'd27;
  localparam logic [4:0] S_PC    = 5'd28;
  localparam logic [4:0] S_OUT   = 5'd29;

  logic [4:0] state_r, state_nxt;
  logic [4:0] ret_r, ret_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ov_nxt    = ov_r & ~out_tready;
    in_tready = 1'b0;
    cmd       = '{op: OP_NOP, msel: MS_PRED, dsel: DS_RATE};
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = status.torque_mode ? S_SHIFT : S_PMUL;
        end
      end
      S_SHIFT: begin cmd.op = OP_SHIFT; state_nxt = S_PRED; end
      S_PRED: begin
        cmd.op = OP_MUL; cmd.msel = MS_PRED; ret_nxt = S_ANP; state_nxt = S_WMUL;
      end
      S_WMUL: if (status.mul_done) state_nxt = ret_r;
      S_WDIV: if (status.div_done) state_nxt = ret_r;
      S_ANP:  begin cmd.op = OP_AN_MRES; state_nxt = S_CA1; end
      S_CA1:  begin cmd.op = OP_COMB_A; state_nxt = S_DR1; end
      S_DR1: begin
        cmd.op = OP_DIV; cmd.dsel = DS_RATE; ret_nxt = S_RN1; state_nxt = S_WDIV;
      end
      S_RN1:  begin cmd.op = OP_RN_DIV; state_nxt = S_CW; end
      S_CW:   begin cmd.op = OP_COMB_W; state_nxt = S_MTI; end
      S_MTI: begin
        cmd.op = OP_MUL; cmd.msel = MS_TI; ret_nxt = S_TI; state_nxt = S_WMUL;
      end
      S_TI:   begin cmd.op = OP_TI; state_nxt = S_MDW; end
      S_MDW: begin
        cmd.op = OP_MUL; cmd.msel = MS_DW; ret_nxt = S_MTD; state_nxt = S_WMUL;
      end
      S_MTD: begin
        cmd.op = OP_MUL; cmd.msel = MS_TD; ret_nxt = S_TD; state_nxt = S_WMUL;
      end
      S_TD:   begin cmd.op = OP_TD; state_nxt = S_MTT; end
      S_MTT: begin
        cmd.op = OP_MUL; cmd.msel = MS_TT; ret_nxt = S_TT; state_nxt = S_WMUL;
      end
      S_TT:   begin cmd.op = OP_TT; state_nxt = S_NUM; end
      S_NUM:  begin cmd.op = OP_NUM; state_nxt = S_MDEN; end
      S_MDEN: begin
        cmd.op = OP_MUL; cmd.msel = MS_DEN; ret_nxt = S_DEN; state_nxt = S_WMUL;
      end
      S_DEN:  begin cmd.op = OP_DEN; state_nxt = S_CHK; end
      S_CHK: begin
        if (status.den_zero) begin
          cmd.op    = OP_CORR_ZERO;
          state_nxt = S_ANC;
        end else begin
          cmd.op = OP_MUL; cmd.msel = MS_M; ret_nxt = S_DC; state_nxt = S_WMUL;
        end
      end
      S_DC: begin
        cmd.op = OP_DIV; cmd.dsel = DS_CORR; ret_nxt = S_CORR; state_nxt = S_WDIV;
      end
      S_CORR: begin cmd.op = OP_CORR_DIV; state_nxt = S_ANC; end
      S_ANC:  begin
        cmd.op    = OP_AN_CORR;
        state_nxt = status.torque_mode ? S_CA2 : S_OUT;
      end
      S_CA2:  begin cmd.op = OP_COMB_A; state_nxt = S_DR2; end
      S_DR2: begin
        cmd.op = OP_DIV; cmd.dsel = DS_RATE; ret_nxt = S_RN2; state_nxt = S_WDIV;
      end
      S_RN2:  begin cmd.op = OP_RN_DIV; state_nxt = S_OUT; end
      S_PMUL: begin
        cmd.op = OP_MUL; cmd.msel = MS_PRES; ret_nxt = S_PC; state_nxt = S_WMUL;
      end
      S_PC:   begin cmd.op = OP_CORR_MRES; state_nxt = S_ANC; end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          cmd.op    = OP_OUT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;

endmodule

`default_nettype wire

// ===== rtl/bdf2_rotor_angle_integrator.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - top level
// Advances a rigid rotor by one time step per input word, either by a BDF2
// solve against the applied torque or by a prescribed angular rate.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       slave      in_tvalid/in_tready  tdata: step_dt, applied_torque
//   out_      master     out_tvalid/out_tready tdata: angle, rate, correction;
//                                             tuser: singular
//   cfg_      slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is worked on at a time. A torque-mode step runs the 81-step serial
// divider three times (two rate updates and the correction) and the shared
// 48x16 multiplier for seven passes. A zero denominator skips one pass and
// one division.
// The next input word is taken as soon as the result is in the output
// register, even while that result waits on out_tready.
// Reset is synchronous and active low; it clears the configuration, the angle
// and rate histories and all control state. The configuration port is always
// ready and should only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf2_rotor_angle_integrator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [31:0] step_dt, [79:32] applied_torque
  input  wire logic [bdf2ri_pkg::IN_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [47:0] angle, [95:48] rate, [143:96] correction
  output logic [bdf2ri_pkg::OUT_W-1:0]       out_tdata,
  // [0] singular
  output logic                               out_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bdf2ri_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [bdf2ri_pkg::VW-1:0]     cfg_data
);
  import bdf2ri_pkg::*;

  cmd_t          cmd;
  status_t       status;
  logic [VW-1:0] angle, rate, correction;

  // Configuration writes are plain register loads, so the port never pushes
  // back.
  assign cfg_ready = 1'b1;

  bdf2ri_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  bdf2ri_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_idx        (cfg_index),
    .cfg_wdata      (cfg_data),
    .step_dt        (in_tdata[DT_W-1:0]),
    .applied_torque (in_tdata[IN_W-1:DT_W]),
    .angle          (angle),
    .rate           (rate),
    .correction     (correction),
    .singular       (out_tuser)
  );

  assign out_tdata = {correction, rate, angle};

endmodule

`default_nettype wire

// ===== rtl/bdf2ri_checker.sv =====
// ----------------------------------------------------------------------------
// BDF2 rotor angle integrator - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf2ri_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [bdf2ri_pkg::OUT_W-1:0]  out_tdata,
  input wire logic                          out_tuser,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);
  import bdf2ri_pkg::*;

  // A stalled result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // One word at a time: the block is busy right after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // A singular step never reports a nonzero correction.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_W-1:2*VW] == '0)
    else $error("singular result with nonzero correction");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The configuration port is never back-pressured.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind bdf2_rotor_angle_integrator bdf2ri_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
